// ----- hw/rtl/bpl_pkg.sv -----
// Package for the BSP point leaf walk block.
// Holds table sizes, field widths, payload structs, status codes and node word layout.
// No dependencies.
package bpl_pkg;

  localparam int NODE_DEPTH = 4096;
  localparam int MAX_STEPS  = 256;

  localparam int ADDR_W  = (NODE_DEPTH > 1) ? $clog2(NODE_DEPTH) : 1;
  localparam int IDX_W   = 16;
  localparam int STEP_W  = $clog2(MAX_STEPS + 1);
  localparam int COUNT_W = 13;
  localparam int ACC_W   = 52;
  localparam int PROD_W  = 48;
  localparam int NODE_W  = 112;

  localparam int LEAF_W      = 15;
  localparam int STATUS_W    = 2;
  localparam int STEPS_OUT_W = 9;

  localparam logic       CMD_WRITE = 1'b0;
  localparam logic       CMD_QUERY = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DEPTH = 2'd2;

  // dist * 2^14 is subtracted: formed as dist * (-16384), then added
  localparam logic signed [15:0] DIST_SCALE_NEG = 16'shC000;

  typedef struct packed {
    logic               command;
    logic [11:0]        node_index;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [31:0] plane_dist;
    logic signed [15:0] child_front;
    logic signed [15:0] child_back;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } item_t;

  typedef struct packed {
    logic [LEAF_W-1:0]      leaf_index;
    logic [STATUS_W-1:0]    status;
    logic [STEPS_OUT_W-1:0] steps_taken;
  } result_t;

  typedef struct packed {
    logic signed [15:0] child_back;
    logic signed [15:0] child_front;
    logic signed [31:0] plane_dist;
    logic signed [15:0] normal_z;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_x;
  } node_t;

  typedef struct packed {
    logic               valid;
    logic               first;
    logic signed [15:0] a;
    logic signed [31:0] b;
  } mac_op_t;

endpackage

// ----- hw/rtl/bpl_ram.sv -----
// Generic simple dual-port RAM, one write port, one read port, registered read.
// No dependencies.
module bpl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/bpl_mac.sv -----
// Shared multiply-accumulate unit: one 16x32 signed product per cycle, registered,
// then summed into a wide accumulator. Depends on bpl_pkg.
module bpl_mac (
  input  logic                              clk,
  input  logic                              rst,
  input  bpl_pkg::mac_op_t                  op,
  output logic signed [bpl_pkg::ACC_W-1:0]  acc
);

  logic signed [bpl_pkg::PROD_W-1:0] prod;
  logic                              prod_vld;
  logic                              prod_first;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld   <= 1'b0;
      prod_first <= 1'b0;
    end else begin
      prod_vld   <= op.valid;
      prod_first <= op.first;
    end
  end

  always_ff @(posedge clk) begin
    if (op.valid) begin
      prod <= op.a * op.b;
    end
    if (prod_vld) begin
      if (prod_first) begin
        acc <= bpl_pkg::ACC_W'(prod);
      end else begin
        acc <= acc + bpl_pkg::ACC_W'(prod);
      end
    end
  end

`ifndef SYNTHESIS
  a_vld_follows_op: assert property (@(posedge clk) disable iff (rst)
    op.valid |=> prod_vld)
    else $error("product valid lost");
  a_first_follows_op: assert property (@(posedge clk) disable iff (rst)
    (op.valid && op.first) |=> prod_first)
    else $error("first product flag lost");
  a_no_first_without_op: assert property (@(posedge clk) disable iff (rst)
    (prod_vld && prod_first) |-> $past(op.first))
    else $error("accumulator cleared without first product");
`endif

endmodule

// ----- hw/rtl/bsp_point_leaf_walk_top.sv -----
// Top level of the BSP point leaf walk: node table, walk sequencer, config register.
// Depends on bpl_pkg, bpl_ram and bpl_mac.
//
//   channel   signals                         transfer
//   item      start, busy, item               start && !busy
//   result    done, result                    done (one cycle, no backpressure)
//   config    cfg_valid, cfg_ready, cfg_data  cfg_valid && cfg_ready
//
// A write item's result strobes in the next cycle.
// Each node a query visits goes through table read, four products through the
// shared multiplier, final add and branch; a stop on range or depth adds a check step.
// The result strobes in the first cycle with busy low again.
// busy is high for the whole walk; cfg_ready is always high; results are never stalled.
// Synchronous reset clears control and node_count; the table is not cleared.
module bsp_point_leaf_walk_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  bpl_pkg::item_t                 item,
  output logic                           done,
  output bpl_pkg::result_t               result,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bpl_pkg::COUNT_W-1:0]    cfg_data
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_MUL    = 3'd2;
  localparam logic [2:0] S_SUM    = 3'd3;
  localparam logic [2:0] S_DECIDE = 3'd4;

  logic [2:0]                      state;
  logic [1:0]                      k;
  logic [bpl_pkg::IDX_W-1:0]       idx;
  logic [bpl_pkg::STEP_W-1:0]      steps;
  logic [bpl_pkg::COUNT_W-1:0]     node_count;
  logic signed [31:0]              px;
  logic signed [31:0]              py;
  logic signed [31:0]              pz;

  logic [bpl_pkg::IDX_W-1:0]       limit;
  logic [bpl_pkg::IDX_W-1:0]       count_ext;
  logic [bpl_pkg::IDX_W-1:0]       wr_idx;
  logic                            accept;
  logic                            wr_en;
  logic                            rd_en;
  logic [bpl_pkg::NODE_W-1:0]      rdata;
  bpl_pkg::node_t                  node;
  bpl_pkg::node_t                  wnode;
  bpl_pkg::mac_op_t                op;
  logic signed [bpl_pkg::ACC_W-1:0] acc;
  logic signed [15:0]              child;

  assign cfg_ready = 1'b1;
  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;

  assign count_ext = bpl_pkg::IDX_W'(node_count);
  assign limit     = (count_ext < bpl_pkg::IDX_W'(bpl_pkg::NODE_DEPTH)) ?
                     count_ext : bpl_pkg::IDX_W'(bpl_pkg::NODE_DEPTH);
  assign wr_idx    = bpl_pkg::IDX_W'(item.node_index);

  assign wr_en = accept && (item.command == bpl_pkg::CMD_WRITE) &&
                 (wr_idx < bpl_pkg::IDX_W'(bpl_pkg::NODE_DEPTH));
  assign rd_en = (state == S_CHECK) && (idx < limit) &&
                 (steps < bpl_pkg::STEP_W'(bpl_pkg::MAX_STEPS));

  always_comb begin
    wnode.child_back  = item.child_back;
    wnode.child_front = item.child_front;
    wnode.plane_dist  = item.plane_dist;
    wnode.normal_z    = item.normal_z;
    wnode.normal_y    = item.normal_y;
    wnode.normal_x    = item.normal_x;
  end

  bpl_ram #(
    .WIDTH (bpl_pkg::NODE_W),
    .DEPTH (bpl_pkg::NODE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_idx[bpl_pkg::ADDR_W-1:0]),
    .wdata (wnode),
    .re    (rd_en),
    .raddr (idx[bpl_pkg::ADDR_W-1:0]),
    .rdata (rdata)
  );

  assign node = bpl_pkg::node_t'(rdata);

  always_comb begin
    op.valid = (state == S_MUL);
    op.first = (k == 2'd0);
    case (k)
      2'd0: begin
        op.a = bpl_pkg::DIST_SCALE_NEG;
        op.b = node.plane_dist;
      end
      2'd1: begin
        op.a = node.normal_x;
        op.b = px;
      end
      2'd2: begin
        op.a = node.normal_y;
        op.b = py;
      end
      2'd3: begin
        op.a = node.normal_z;
        op.b = pz;
      end
      default: begin
        op.a = '0;
        op.b = '0;
      end
    endcase
  end

  bpl_mac u_mac (
    .clk (clk),
    .rst (rst),
    .op  (op),
    .acc (acc)
  );

  assign child = acc[bpl_pkg::ACC_W-1] ? node.child_back : node.child_front;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      node_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && item.command == bpl_pkg::CMD_QUERY) begin
      px <= item.point_x;
      py <= item.point_y;
      pz <= item.point_z;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      done   <= 1'b0;
      k      <= '0;
      idx    <= '0;
      steps  <= '0;
      result <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (item.command == bpl_pkg::CMD_WRITE) begin
              done               <= 1'b1;
              result.leaf_index  <= '0;
              result.steps_taken <= '0;
              result.status      <= wr_en ? bpl_pkg::ST_OK : bpl_pkg::ST_RANGE;
            end else begin
              idx   <= wr_idx;
              steps <= '0;
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          if (idx >= limit) begin
            done               <= 1'b1;
            result.leaf_index  <= '0;
            result.status      <= bpl_pkg::ST_RANGE;
            result.steps_taken <= bpl_pkg::STEPS_OUT_W'(steps);
            state              <= S_IDLE;
          end else if (steps >= bpl_pkg::STEP_W'(bpl_pkg::MAX_STEPS)) begin
            done               <= 1'b1;
            result.leaf_index  <= '0;
            result.status      <= bpl_pkg::ST_DEPTH;
            result.steps_taken <= bpl_pkg::STEPS_OUT_W'(steps);
            state              <= S_IDLE;
          end else begin
            steps <= steps + bpl_pkg::STEP_W'(1);
            k     <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          k <= k + 2'd1;
          if (k == 2'd3) begin
            state <= S_SUM;
          end
        end
        S_SUM: begin
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (child[15]) begin
            done               <= 1'b1;
            result.leaf_index  <= ~child[bpl_pkg::LEAF_W-1:0];
            result.status      <= bpl_pkg::ST_OK;
            result.steps_taken <= bpl_pkg::STEPS_OUT_W'(steps);
            state              <= S_IDLE;
          end else begin
            idx   <= bpl_pkg::IDX_W'(child[14:0]);
            state <= S_CHECK;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_accept_moves: assert property (@(posedge clk) disable iff (rst)
    accept |=> (busy || done))
    else $error("accepted item neither walked nor answered");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy || $past(state == S_IDLE))
    else $error("result strobe during walk");
  a_depth_steps: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == bpl_pkg::ST_DEPTH) |->
      result.steps_taken == bpl_pkg::STEPS_OUT_W'(bpl_pkg::MAX_STEPS))
    else $error("depth error with wrong step count");
  a_steps_bound: assert property (@(posedge clk) disable iff (rst)
    steps <= bpl_pkg::STEP_W'(bpl_pkg::MAX_STEPS))
    else $error("step counter overran limit");
  a_decide_visited: assert property (@(posedge clk) disable iff (rst)
    (state == S_DECIDE) |-> (steps != '0) && $past(state == S_SUM))
    else $error("branch without a visited node");
`endif

endmodule
